FILE: rtl/core/ray_disc_intersect_defines.svh
// Assertion macros shared by the ray-disc intersection checker.
// No dependencies; include this file by its bare name.
`ifndef RAY_DISC_INTERSECT_DEFINES_SVH
`define RAY_DISC_INTERSECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RDI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray_disc_intersect: assertion failed");

// Next-cycle implication, disabled during reset.
`define RDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray_disc_intersect: assertion failed");

`endif

FILE: rtl/core/rdi_pkg.sv
// Types and constants shared by the ray-disc intersection pipeline.
// No dependencies.
package rdi_pkg;

  localparam int SUM_W     = 66;
  localparam int MAG_W     = 64;
  localparam int T_W       = 31;
  localparam int DIV_STEPS = 31;

  localparam logic [2:0] REG_CENTER_X     = 3'd0;
  localparam logic [2:0] REG_CENTER_Y     = 3'd1;
  localparam logic [2:0] REG_CENTER_Z     = 3'd2;
  localparam logic [2:0] REG_NORMAL_X     = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y     = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z     = 3'd5;
  localparam logic [2:0] REG_DISC_RADIUS  = 3'd6;
  localparam logic [2:0] REG_PLANE_OFFSET = 3'd7;

  localparam logic OP_CLOSEST = 1'b0;
  localparam logic OP_SHADOW  = 1'b1;

  localparam logic signed [31:0] NORMAL_ONE     = 32'sd1073741824;
  localparam logic signed [31:0] NORMAL_NEG_ONE = -32'sd1073741824;
  localparam logic [T_W-1:0]     T_MAX          = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]        disc_radius;
    logic signed [31:0] plane_offset;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic               prior_hit;
    logic [30:0]        prior_distance;
  } ray_t;

  typedef struct packed {
    ray_t                    ray;
    logic                    parallel;
    logic signed [SUM_W-1:0] dot;
    logic signed [SUM_W-1:0] num;
  } plane_t;

  typedef struct packed {
    ray_t           ray;
    logic           parallel;
    logic           neg;
    logic           ovf;
    logic [T_W-1:0] quot;
  } divq_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_distance;
    logic        occluded;
  } result_t;

endpackage

FILE: rtl/core/rdi_plane.sv
// Plane stage: direction and origin dot products with the disc normal.
// Depends on rdi_pkg.
module rdi_plane #(
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  rdi_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  rdi_pkg::ray_t   in_ray,
  output logic            out_valid,
  input  logic            out_ready,
  output rdi_pkg::plane_t out_data
);

  localparam int SW = rdi_pkg::SUM_W;
  localparam logic signed [SW-1:0] DOT_EPS =
    (SW'(1) << (FRACTION_BITS + 30)) / SW'(1000000);
  localparam logic signed [SW-1:0] NEG_DOT_EPS = -DOT_EPS;

  logic                 a_v, b_v, en_a, en_b;
  rdi_pkg::ray_t        a_ray;
  logic signed [63:0]   a_pdx, a_pdy, a_pdz, a_pox, a_poy, a_poz;
  logic signed [SW-1:0] dot_sum, num_sum;
  rdi_pkg::plane_t      b_data;

  assign en_b     = !b_v || out_ready;
  assign en_a     = !a_v || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en_a) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_ray <= in_ray;
      a_pdx <= in_ray.direction_x * cfg.normal_x;
      a_pdy <= in_ray.direction_y * cfg.normal_y;
      a_pdz <= in_ray.direction_z * cfg.normal_z;
      a_pox <= in_ray.origin_x * cfg.normal_x;
      a_poy <= in_ray.origin_y * cfg.normal_y;
      a_poz <= in_ray.origin_z * cfg.normal_z;
    end
  end

  assign dot_sum = SW'(a_pdx) + SW'(a_pdy) + SW'(a_pdz);
  assign num_sum = (SW'(cfg.plane_offset) <<< 30) - (SW'(a_pox) + SW'(a_poy) + SW'(a_poz));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en_b) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_data.ray      <= a_ray;
      b_data.dot      <= dot_sum;
      b_data.num      <= num_sum;
      b_data.parallel <= (dot_sum < DOT_EPS) && (dot_sum > NEG_DOT_EPS);
    end
  end

  assign out_valid = b_v;
  assign out_data  = b_data;

endmodule

FILE: rtl/core/rdi_div.sv
// Restoring divider pipeline, one quotient bit per stage, for the plane distance.
// Depends on rdi_pkg.
module rdi_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rdi_pkg::plane_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rdi_pkg::divq_t  out_data
);

  localparam int S  = rdi_pkg::DIV_STEPS;
  localparam int MW = rdi_pkg::MAG_W;
  localparam int TW = rdi_pkg::T_W;

  logic                    m_v, m_en;
  rdi_pkg::ray_t           m_ray;
  logic                    m_parallel, m_neg;
  logic [MW-1:0]           m_n, m_d;
  logic [rdi_pkg::SUM_W-1:0] num_mag, dot_mag;
  logic [MW-1:0]           rem0;

  logic                    st_v   [0:S];
  logic                    en     [0:S];
  rdi_pkg::divq_t          st_data[0:S];
  logic [MW-1:0]           st_rem [0:S];
  logic [TW-1:0]           st_low [0:S];
  logic [MW-1:0]           st_d   [0:S];

  assign num_mag = in_data.num[rdi_pkg::SUM_W-1] ? -in_data.num : in_data.num;
  assign dot_mag = in_data.dot[rdi_pkg::SUM_W-1] ? -in_data.dot : in_data.dot;

  assign m_en     = !m_v || en[0];
  assign in_ready = m_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_en) begin
      m_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_en) begin
      m_ray      <= in_data.ray;
      m_parallel <= in_data.parallel;
      m_neg      <= in_data.num[rdi_pkg::SUM_W-1] ^ in_data.dot[rdi_pkg::SUM_W-1];
      m_n        <= num_mag[MW-1:0];
      m_d        <= dot_mag[MW-1:0];
    end
  end

  assign rem0 = m_n >> (31 - FRACTION_BITS);

  // Stage 0 holds the dividend bits above the quotient width; a value at or above the divisor saturates t.
  assign en[S] = !st_v[S] || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (en[0]) begin
      st_v[0] <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st_data[0].ray      <= m_ray;
      st_data[0].parallel <= m_parallel;
      st_data[0].neg      <= m_neg;
      st_data[0].ovf      <= rem0 >= m_d;
      st_data[0].quot     <= '0;
      st_rem[0]           <= rem0;
      st_low[0]           <= TW'(m_n << FRACTION_BITS);
      st_d[0]             <= m_d;
    end
  end

  for (genvar k = 1; k <= S; k++) begin : g_step
    logic [MW:0] shifted, diff;
    logic        take;

    assign shifted = {st_rem[k-1], st_low[k-1][TW-1]};
    assign diff    = shifted - {1'b0, st_d[k-1]};
    assign take    = shifted >= {1'b0, st_d[k-1]};
    assign en[k-1] = !st_v[k-1] || en[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en[k]) begin
        st_v[k] <= st_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_data[k].ray      <= st_data[k-1].ray;
        st_data[k].parallel <= st_data[k-1].parallel;
        st_data[k].neg      <= st_data[k-1].neg;
        st_data[k].ovf      <= st_data[k-1].ovf;
        st_data[k].quot     <= {st_data[k-1].quot[TW-2:0], take};
        st_rem[k]           <= take ? diff[MW-1:0] : shifted[MW-1:0];
        st_low[k]           <= {st_low[k-1][TW-2:0], 1'b0};
        st_d[k]             <= st_d[k-1];
      end
    end
  end

  assign out_valid = st_v[S];
  assign out_data  = st_data[S];

endmodule

FILE: rtl/core/rdi_point.sv
// Hit point stage: ray range checks, hit point, squared radius test, result.
// Depends on rdi_pkg.
module rdi_point #(
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  rdi_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  rdi_pkg::divq_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rdi_pkg::result_t out_data
);

  localparam int SW = rdi_pkg::SUM_W;
  localparam logic signed [31:0] T_EPS = 32'((64'd1 << FRACTION_BITS) / 64'd1000000);

  logic e0, e1, e2, e3, e4, e5;
  logic v0, v1, v2, v3, v4, v5;

  logic [30:0]          t_mag;
  logic signed [31:0]   t_pos, t_val, pdist;
  logic                 range_ok;

  rdi_pkg::ray_t        p0_ray;
  logic                 p0_parallel;
  logic signed [31:0]   p0_t;

  rdi_pkg::ray_t        p1_ray;
  logic signed [31:0]   p1_t;
  logic                 p1_ok;
  logic signed [63:0]   p1_pdx, p1_pdy, p1_pdz;

  logic                 p2_op, p2_ok;
  logic signed [31:0]   p2_t;
  logic signed [SW-1:0] p2_dfx, p2_dfy, p2_dfz;

  logic [SW-1:0]        mag_x, mag_y, mag_z;
  logic                 p3_op, p3_ok;
  logic signed [31:0]   p3_t;
  logic [30:0]          p3_mx, p3_my, p3_mz;

  logic                 p4_op, p4_ok;
  logic signed [31:0]   p4_t;
  logic [61:0]          p4_sx, p4_sy, p4_sz, p4_r2;

  logic [63:0]          acc;
  logic                 final_ok;
  rdi_pkg::result_t     res;

  assign e5       = !v5 || out_ready;
  assign e4       = !v4 || e5;
  assign e3       = !v3 || e4;
  assign e2       = !v2 || e3;
  assign e1       = !v1 || e2;
  assign e0       = !v0 || e1;
  assign in_ready = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (e0) begin
        v0 <= in_valid;
      end
      if (e1) begin
        v1 <= v0;
      end
      if (e2) begin
        v2 <= v1;
      end
      if (e3) begin
        v3 <= v2;
      end
      if (e4) begin
        v4 <= v3;
      end
      if (e5) begin
        v5 <= v4;
      end
    end
  end

  // Signed, saturated t.
  assign t_mag = in_data.ovf ? rdi_pkg::T_MAX : in_data.quot;
  assign t_pos = signed'({1'b0, t_mag});
  assign t_val = in_data.neg ? -t_pos : t_pos;

  always_ff @(posedge clk) begin
    if (e0) begin
      p0_ray      <= in_data.ray;
      p0_parallel <= in_data.parallel;
      p0_t        <= t_val;
    end
  end

  assign pdist = signed'({1'b0, p0_ray.prior_distance});

  always_comb begin
    case (p0_ray.opcode)
      rdi_pkg::OP_CLOSEST: range_ok = (p0_t > T_EPS) && !(p0_ray.prior_hit && (p0_t >= pdist));
      default:             range_ok = (p0_t > 32'sd0) && (p0_t < pdist);
    endcase
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      p1_ray <= p0_ray;
      p1_t   <= p0_t;
      p1_ok  <= !p0_parallel && range_ok;
      p1_pdx <= p0_ray.direction_x * p0_t;
      p1_pdy <= p0_ray.direction_y * p0_t;
      p1_pdz <= p0_ray.direction_z * p0_t;
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      p2_op  <= p1_ray.opcode;
      p2_ok  <= p1_ok;
      p2_t   <= p1_t;
      p2_dfx <= SW'(p1_ray.origin_x) + SW'(p1_pdx >>> FRACTION_BITS) - SW'(cfg.center_x);
      p2_dfy <= SW'(p1_ray.origin_y) + SW'(p1_pdy >>> FRACTION_BITS) - SW'(cfg.center_y);
      p2_dfz <= SW'(p1_ray.origin_z) + SW'(p1_pdz >>> FRACTION_BITS) - SW'(cfg.center_z);
    end
  end

  assign mag_x = p2_dfx[SW-1] ? -p2_dfx : p2_dfx;
  assign mag_y = p2_dfy[SW-1] ? -p2_dfy : p2_dfy;
  assign mag_z = p2_dfz[SW-1] ? -p2_dfz : p2_dfz;

  always_ff @(posedge clk) begin
    if (e3) begin
      p3_op <= p2_op;
      p3_t  <= p2_t;
      p3_ok <= p2_ok && (mag_x < SW'(cfg.disc_radius)) && (mag_y < SW'(cfg.disc_radius))
               && (mag_z < SW'(cfg.disc_radius));
      p3_mx <= mag_x[30:0];
      p3_my <= mag_y[30:0];
      p3_mz <= mag_z[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (e4) begin
      p4_op <= p3_op;
      p4_t  <= p3_t;
      p4_ok <= p3_ok;
      p4_sx <= p3_mx * p3_mx;
      p4_sy <= p3_my * p3_my;
      p4_sz <= p3_mz * p3_mz;
      p4_r2 <= cfg.disc_radius * cfg.disc_radius;
    end
  end

  assign acc      = 64'(p4_sx) + 64'(p4_sy) + 64'(p4_sz);
  assign final_ok = p4_ok && (acc < 64'(p4_r2));

  always_ff @(posedge clk) begin
    if (e5) begin
      res.hit          <= final_ok && (p4_op == rdi_pkg::OP_CLOSEST);
      res.hit_distance <= (final_ok && (p4_op == rdi_pkg::OP_CLOSEST)) ? p4_t[30:0] : 31'd0;
      res.occluded     <= final_ok && (p4_op == rdi_pkg::OP_SHADOW);
    end
  end

  assign out_valid = v5;
  assign out_data  = res;

endmodule

FILE: rtl/core/ray_disc_intersect.sv
// Ray against disc intersection test, fully pipelined.
// Depends on rdi_pkg, rdi_plane, rdi_div and rdi_point.
//
// Rays enter on the s_ group: opcode in s_tuser, the ray and prior distance
// in s_tdata. One result per ray leaves on the m_ group in the same order.
// The disc is set through the write port (cfg_we, cfg_index, cfg_data),
// which may only be written while no request is in flight.
// Throughput is one ray per clock while m_tready is high. From acceptance to
// m_tvalid a ray passes the dot-product registers, the divider set-up
// registers, the restoring divider that yields one bit of t per stage, and
// the registers for the hit point, the radius test and the output.
// Reset clears every stage valid bit and loads the default disc: centre at
// the origin, normal along +z and radius 1.0.
// When m_tready is low the output register holds its result; every stage
// carries its own valid bit, so earlier stages keep filling bubbles until
// the pipeline is full, and only then is s_tready dropped.
module ray_disc_intersect #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
  // prior_hit, prior_distance
  input  logic [223:0] s_tdata,
  // opcode
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, hit_distance, occluded, zero padding
  output logic [39:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  rdi_pkg::cfg_t      cfg;
  rdi_pkg::ray_t      ray_in;
  rdi_pkg::plane_t    plane_data;
  rdi_pkg::divq_t     div_data;
  rdi_pkg::result_t   res;
  logic               plane_valid, plane_ready, div_valid, div_ready;
  logic signed [31:0] wr_data, wr_normal;

  assign wr_data   = cfg_data;
  assign wr_normal = (wr_data > rdi_pkg::NORMAL_ONE) ? rdi_pkg::NORMAL_ONE :
                     (wr_data < rdi_pkg::NORMAL_NEG_ONE) ? rdi_pkg::NORMAL_NEG_ONE : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x     <= '0;
      cfg.center_y     <= '0;
      cfg.center_z     <= '0;
      cfg.normal_x     <= '0;
      cfg.normal_y     <= '0;
      cfg.normal_z     <= rdi_pkg::NORMAL_ONE;
      cfg.disc_radius  <= 31'd65536;
      cfg.plane_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdi_pkg::REG_CENTER_X:     cfg.center_x     <= wr_data;
        rdi_pkg::REG_CENTER_Y:     cfg.center_y     <= wr_data;
        rdi_pkg::REG_CENTER_Z:     cfg.center_z     <= wr_data;
        rdi_pkg::REG_NORMAL_X:     cfg.normal_x     <= wr_normal;
        rdi_pkg::REG_NORMAL_Y:     cfg.normal_y     <= wr_normal;
        rdi_pkg::REG_NORMAL_Z:     cfg.normal_z     <= wr_normal;
        rdi_pkg::REG_DISC_RADIUS:  cfg.disc_radius  <= cfg_data[30:0];
        rdi_pkg::REG_PLANE_OFFSET: cfg.plane_offset <= wr_data;
        default: ;
      endcase
    end
  end

  assign ray_in.opcode         = s_tuser[0];
  assign ray_in.origin_x       = s_tdata[31:0];
  assign ray_in.origin_y       = s_tdata[63:32];
  assign ray_in.origin_z       = s_tdata[95:64];
  assign ray_in.direction_x    = s_tdata[127:96];
  assign ray_in.direction_y    = s_tdata[159:128];
  assign ray_in.direction_z    = s_tdata[191:160];
  assign ray_in.prior_hit      = s_tdata[192];
  assign ray_in.prior_distance = s_tdata[223:193];

  rdi_plane #(.FRACTION_BITS(FRACTION_BITS)) u_plane (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ray    (ray_in),
    .out_valid (plane_valid),
    .out_ready (plane_ready),
    .out_data  (plane_data)
  );

  rdi_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (plane_valid),
    .in_ready  (plane_ready),
    .in_data   (plane_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  rdi_point #(.FRACTION_BITS(FRACTION_BITS)) u_point (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {7'd0, res.occluded, res.hit_distance, res.hit};

endmodule

FILE: rtl/core/rdi_checker.sv
// Port-level checks on the result stream of the ray-disc intersection block.
// Depends on ray_disc_intersect_defines.svh; bound to ray_disc_intersect.
`include "ray_disc_intersect_defines.svh"

module rdi_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  `RDI_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `RDI_ASSERT_NOW(a_one_kind, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[32]))
  `RDI_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[31:1] == 31'd0)
  `RDI_ASSERT_NOW(a_hit_ahead, clk, rst, m_tvalid && m_tdata[0], m_tdata[31:1] != 31'd0)

endmodule

bind ray_disc_intersect rdi_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
